/* sv/rpi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared types and constants of the ray-plane intersection block.
// ----------------------------------------------------------------------------
package rpi_pkg;

    // default fraction bits of the fixed-point coordinates
    localparam int FRAC_BITS_DEF = 16;
    // largest fraction width supported
    localparam int FRAC_BITS_MAX = 24;
    // shifted numerator magnitude: 65 bits plus the largest fraction shift
    localparam int NM_W          = 65 + FRAC_BITS_MAX;
    // quotient bits resolved by the divider, one per stage
    localparam int DIV_STEPS     = 32;
    // entries of the queue between front and back
    localparam int QUEUE_DEPTH   = 4;
    localparam int QP_W          = $clog2(QUEUE_DEPTH);

    // one input request
    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
    } t_ray_in;

    // one result request
    typedef struct packed {
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic               parallel;
        logic               saturated;
    } t_hit_out;

    // origin and direction carried to the back end
    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
    } t_ray_od;

    // classified request handed from front to back
    typedef struct packed {
        logic [NM_W-1:0] nm;    // |n.(p-o)| << frac bits
        logic [63:0]     dm;    // |n.d|
        logic            ovf;   // quotient needs more than 32 bits
        logic            neg;   // quotient is negative
        logic            par;   // n.d is zero
        t_ray_od         od;
    } t_mid;

    // one divider stage
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] dm;
        logic [31:0] low;
        logic [31:0] q;
        logic        ovf;
        logic        neg;
        logic        par;
        t_ray_od     od;
    } t_div;

endpackage

/* sv/rpi_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_front
// Takes requests, forms both dot products, signs and magnitudes, flags
// parallel rays and quotient overflow, and pushes into the queue.
// ----------------------------------------------------------------------------
module rpi_front import rpi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_ray_in i_ray,
    output logic    o_stall,
    output logic    o_push,
    output t_mid    o_mid,
    input  logic    i_full
);

    logic               en;
    logic               r_vld1, r_vld2, r_vld3;
    t_ray_in            r_ray1;
    t_ray_od            r_od2, r_od3;
    logic signed [64:0] r_pn2 [3];
    logic signed [63:0] r_pd2 [3];
    logic signed [66:0] r_num3;
    logic signed [65:0] r_den3;
    logic signed [32:0] diff_x, diff_y, diff_z;
    logic signed [66:0] num_abs;
    logic signed [65:0] den_abs;
    logic [NM_W-1:0]    nm_sh;

    // pipeline moves unless the last stage waits on a full queue
    assign en      = !(r_vld3 && i_full);
    assign o_stall = !en;
    assign o_push  = r_vld3;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    // vertex minus origin, 33 bits
    assign diff_x = $signed({r_ray1.vertex_x[31], r_ray1.vertex_x})
                  - $signed({r_ray1.origin_x[31], r_ray1.origin_x});
    assign diff_y = $signed({r_ray1.vertex_y[31], r_ray1.vertex_y})
                  - $signed({r_ray1.origin_y[31], r_ray1.origin_y});
    assign diff_z = $signed({r_ray1.vertex_z[31], r_ray1.vertex_z})
                  - $signed({r_ray1.origin_z[31], r_ray1.origin_z});

    // input register, products, then sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ray1   <= i_ray;
            r_pn2[0] <= r_ray1.norm_x * diff_x;
            r_pn2[1] <= r_ray1.norm_y * diff_y;
            r_pn2[2] <= r_ray1.norm_z * diff_z;
            r_pd2[0] <= r_ray1.norm_x * r_ray1.dir_x;
            r_pd2[1] <= r_ray1.norm_y * r_ray1.dir_y;
            r_pd2[2] <= r_ray1.norm_z * r_ray1.dir_z;
            r_od2    <= '{ox: r_ray1.origin_x, oy: r_ray1.origin_y, oz: r_ray1.origin_z,
                          dx: r_ray1.dir_x, dy: r_ray1.dir_y, dz: r_ray1.dir_z};
            r_num3   <= 67'(r_pn2[0]) + 67'(r_pn2[1]) + 67'(r_pn2[2]);
            r_den3   <= 66'(r_pd2[0]) + 66'(r_pd2[1]) + 66'(r_pd2[2]);
            r_od3    <= r_od2;
        end
    end

    // magnitudes, fraction shift and overflow check
    always_comb begin
        num_abs     = r_num3[66] ? -r_num3 : r_num3;
        den_abs     = r_den3[65] ? -r_den3 : r_den3;
        nm_sh       = {{(NM_W-65){1'b0}}, num_abs[64:0]} << FRAC_BITS;
        o_mid.nm    = nm_sh;
        o_mid.dm    = den_abs[63:0];
        o_mid.ovf   = {{(64-(NM_W-32)){1'b0}}, nm_sh[NM_W-1:32]} >= den_abs[63:0];
        o_mid.neg   = r_num3[66] != r_den3[65];
        o_mid.par   = r_den3 == 66'sd0;
        o_mid.od    = r_od3;
    end

endmodule

/* sv/rpi_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module rpi_queue import rpi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_mid i_mid,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_mid o_mid
);

    t_mid          r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wptr, r_rptr;
    logic [QP_W:0]   r_cnt;
    logic          wr, rd;

    assign o_full  = r_cnt == (QP_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_mid   = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) r_wptr <= r_wptr + 1'b1;
            if (rd) r_rptr <= r_rptr + 1'b1;
            r_cnt <= r_cnt + (QP_W+1)'(wr) - (QP_W+1)'(rd);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wptr] <= i_mid;
    end

endmodule

/* sv/rpi_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_back
// Pipelined restoring divider, one quotient bit per stage, then quotient
// clipping, direction scaling, hit point and output register.
// ----------------------------------------------------------------------------
module rpi_back import rpi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_mid     i_mid,
    output logic     o_pop,
    output logic     o_valid,
    output t_hit_out o_hit,
    input  logic     i_stall
);

    logic               en;
    t_div               r_div [DIV_STEPS+1];
    logic               r_dvld [DIV_STEPS+1];
    t_div               n_div [DIV_STEPS+1];
    logic               r_uvld, r_pvld, r_ovld;
    logic signed [31:0] r_u;
    logic               r_usat, r_upar, r_psat, r_ppar;
    t_ray_od            r_uod, r_pod;
    logic signed [63:0] r_p [3];
    t_hit_out           r_out;
    t_div               last;
    logic [32:0]        lim;
    logic               sat_u;
    logic [31:0]        qsel;
    logic signed [63:0] sh [3];
    logic signed [64:0] sum [3];
    logic signed [31:0] hit [3];
    logic [2:0]         clip;
    logic signed [31:0] ocoord [3];

    assign en      = !(r_ovld && i_stall);
    assign o_pop   = en;
    assign o_valid = r_ovld;
    assign o_hit   = r_out;

    // divider stage inputs: load then one restoring step per stage
    always_comb begin
        logic [64:0] t;
        logic        ge;
        n_div[0].rem = {{(64-(NM_W-32)){1'b0}}, i_mid.nm[NM_W-1:32]};
        n_div[0].dm  = i_mid.dm;
        n_div[0].low = i_mid.nm[31:0];
        n_div[0].q   = '0;
        n_div[0].ovf = i_mid.ovf;
        n_div[0].neg = i_mid.neg;
        n_div[0].par = i_mid.par;
        n_div[0].od  = i_mid.od;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            t            = {r_div[k-1].rem, r_div[k-1].low[31]};
            ge           = t >= {1'b0, r_div[k-1].dm};
            n_div[k]     = r_div[k-1];
            n_div[k].rem = ge ? 64'(t - {1'b0, r_div[k-1].dm}) : t[63:0];
            n_div[k].low = {r_div[k-1].low[30:0], 1'b0};
            n_div[k].q   = {r_div[k-1].q[30:0], ge};
        end
    end

    // quotient clipping and sign
    always_comb begin
        last  = r_div[DIV_STEPS];
        lim   = last.neg ? 33'h080000000 : 33'h07FFFFFFF;
        sat_u = last.ovf || ({1'b0, last.q} > lim);
        qsel  = sat_u ? lim[31:0] : last.q;
    end

    // hit coordinates with clipping
    assign ocoord[0] = r_pod.ox;
    assign ocoord[1] = r_pod.oy;
    assign ocoord[2] = r_pod.oz;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sh[i]   = r_p[i] >>> FRAC_BITS;
            sum[i]  = 65'(ocoord[i]) + 65'(sh[i]);
            clip[i] = sum[i][64:31] != {34{sum[i][64]}};
            hit[i]  = clip[i] ? (sum[i][64] ? 32'sh80000000 : 32'sh7FFFFFFF)
                              : sum[i][31:0];
        end
    end

    // valid bits of all back stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) r_dvld[k] <= 1'b0;
            r_uvld <= 1'b0;
            r_pvld <= 1'b0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_dvld[0] <= !i_empty;
            for (int k = 1; k <= DIV_STEPS; k++) r_dvld[k] <= r_dvld[k-1];
            r_uvld <= r_dvld[DIV_STEPS];
            r_pvld <= r_uvld;
            r_ovld <= r_pvld;
        end
    end

    // payload of all back stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= DIV_STEPS; k++) r_div[k] <= n_div[k];
            r_u    <= last.neg ? -$signed(qsel) : $signed(qsel);
            r_usat <= sat_u;
            r_upar <= last.par;
            r_uod  <= last.od;
            r_p[0] <= r_uod.dx * r_u;
            r_p[1] <= r_uod.dy * r_u;
            r_p[2] <= r_uod.dz * r_u;
            r_psat <= r_usat;
            r_ppar <= r_upar;
            r_pod  <= r_uod;
            r_out.hit_x     <= r_ppar ? 32'sd0 : hit[0];
            r_out.hit_y     <= r_ppar ? 32'sd0 : hit[1];
            r_out.hit_z     <= r_ppar ? 32'sd0 : hit[2];
            r_out.parallel  <= r_ppar;
            r_out.saturated <= !r_ppar && (r_psat || (clip != 3'b000));
        end
    end

endmodule

/* sv/ray_plane_intersection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_plane_intersection
// Ray against plane hit point in signed fixed point, one request per cycle while not stalled.
// ----------------------------------------------------------------------------
// Accepts one ray request per clock while not stalled and returns one hit request per
// request, in order. The front stages are the input register, products and sums; the
// back stages are the queue hop, 33 divider stages, clip, multiply and output register;
// the 32-stage pipelined restoring divider sets the depth, and the sustained rate is
// one request per cycle while neither side stalls. A 4-entry queue between the dot
// product front end and the divider back end lets either side stall alone.
module ray_plane_intersection import rpi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_ray_in  i_ray,
    output logic     o_stall,
    output logic     o_valid,
    output t_hit_out o_hit,
    input  logic     i_stall
);

    logic push, full, pop, empty;
    t_mid mid_in, mid_out;

    // dot products and classification
    rpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ray   (i_ray),
        .o_stall (o_stall),
        .o_push  (push),
        .o_mid   (mid_in),
        .i_full  (full)
    );

    // decoupling queue
    rpi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_mid   (mid_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_mid   (mid_out)
    );

    // division and hit point
    rpi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_mid   (mid_out),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_hit   (o_hit),
        .i_stall (i_stall)
    );

endmodule
